/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. All checks are clocked on clk_i and
// held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define NPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define NPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/npq_pkg.sv */
// ---------------------------------------------------------------------------
// npq_pkg
// Field widths, register codes and operation codes of the nearest palette
// quantiser.
// ---------------------------------------------------------------------------
package npq_pkg;

  // Fixed field widths of a beat
  localparam int unsigned ENTRY_INDEX_W   = 4;
  localparam int unsigned COLOR_INDEX_W   = 4;
  localparam int unsigned NUM_VALUE_FIELDS = 4;

  // Configuration port
  localparam int unsigned NUM_COLORS_W   = 5;
  localparam int unsigned NUM_CHANNELS_W = 3;
  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned CFG_INDEX_W    = 1;

  localparam logic [NUM_COLORS_W-1:0]   NUM_COLORS_RST   = 5'd16;
  localparam logic [NUM_CHANNELS_W-1:0] NUM_CHANNELS_RST = 3'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NUM_COLORS   = 1'b0,
    CFG_NUM_CHANNELS = 1'b1
  } cfg_reg_e;

  // Carried in tuser of the input stream
  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUANT = 1'b1
  } op_e;

endpackage

/* hw/rtl/nearest_palette_quantizer_core.sv */
// Throughput: one pixel per cycle while m_axis_tready keeps the output register free;
// every palette distance is worked out side by side.
// A palette write waits until no pixel is left between input and output register.
// Reset clears the valid bits and loads num_colors = 16, num_channels = 3.
// The palette holds no reset value; entries must be written before use.
// ---------------------------------------------------------------------------
// nearest_palette_quantizer_core
// Replaces each pixel by the nearest palette colour (squared Euclidean
// distance, lowest index on a tie). Stages: difference, square, channel sum,
// registered min tree (one level per stage), colour lookup into the output
// register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_palette_quantizer_core #(
  parameter int unsigned MAX_COLORS   = 16,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Configuration writes
  input  logic                             cfg_we_i,
  input  logic [npq_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [npq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,

  // Input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: entry_index, value0, value1, value2, value3, zero pad
  input  logic [((npq_pkg::ENTRY_INDEX_W + npq_pkg::NUM_VALUE_FIELDS * SAMPLE_BITS + 7) / 8)
                * 8 - 1:0] s_axis_tdata,
  // tuser: op
  input  logic s_axis_tuser,
  input  logic s_axis_tlast,

  // Output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: color_index, out_value0, out_value1, out_value2, out_value3, zero pad
  output logic [((npq_pkg::COLOR_INDEX_W + npq_pkg::NUM_VALUE_FIELDS * SAMPLE_BITS + 7) / 8)
                * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  import npq_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_COLORS);
  localparam int unsigned NPOW   = 1 << IDX_W;
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned OUT_W  = ((COLOR_INDEX_W + NUM_VALUE_FIELDS * SAMPLE_BITS + 7) / 8) * 8;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [NUM_COLORS_W-1:0]   num_colors_q;
  logic [NUM_CHANNELS_W-1:0] num_channels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_colors_q   <= NUM_COLORS_RST;
      num_channels_q <= NUM_CHANNELS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_COLORS:   num_colors_q   <= cfg_wdata_i[NUM_COLORS_W-1:0];
        CFG_NUM_CHANNELS: num_channels_q <= cfg_wdata_i[NUM_CHANNELS_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel k and colour j take part; zero counts act as one
  logic [MAX_CHANNELS-1:0] chan_act;
  logic [MAX_COLORS-1:0]   color_act;

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      chan_act[k] = (k == 0) || (int'(num_channels_q) > k);
    end
    for (int j = 0; j < MAX_COLORS; j++) begin
      color_act[j] = (j == 0) || (int'(num_colors_q) > j);
    end
  end

  // -------------------------------------------------------------------------
  // Input beat decode
  // -------------------------------------------------------------------------
  op_e                          in_op;
  logic [ENTRY_INDEX_W-1:0]     in_entry;
  logic signed [SAMPLE_BITS-1:0] in_value [NUM_VALUE_FIELDS];
  logic [IDX_W+ENTRY_INDEX_W-1:0] wr_addr_ext;
  logic [IDX_W-1:0]             wr_addr;

  always_comb begin
    in_op    = op_e'(s_axis_tuser);
    in_entry = s_axis_tdata[ENTRY_INDEX_W-1:0];
    for (int k = 0; k < NUM_VALUE_FIELDS; k++) begin
      in_value[k] = s_axis_tdata[ENTRY_INDEX_W + k * SAMPLE_BITS +: SAMPLE_BITS];
    end
    wr_addr_ext = {{IDX_W{1'b0}}, in_entry};
    wr_addr     = wr_addr_ext[IDX_W-1:0];
  end

  // -------------------------------------------------------------------------
  // Handshake and pipeline advance
  // -------------------------------------------------------------------------
  logic               pipe_en;
  logic               pix_busy;
  logic               in_fire;
  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  logic [IDX_W-1:0]   tree_v_q;
  logic               out_valid_q;

  // Output register free or being emptied this cycle
  assign pipe_en  = !out_valid_q || m_axis_tready;
  // A pixel still reads the palette somewhere before the output register
  assign pix_busy = s1_valid_q || s2_valid_q || s3_valid_q || (|tree_v_q);

  assign s_axis_tready = pipe_en && ((in_op == OP_QUANT) || !pix_busy);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // -------------------------------------------------------------------------
  // Palette store, written on a palette beat
  // -------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] palette_q [MAX_COLORS][MAX_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (in_fire && (in_op == OP_WRITE) && (int'(in_entry) < MAX_COLORS)) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        palette_q[wr_addr][k] <= in_value[k];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: per-colour channel differences
  // -------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] s1_diff_d [MAX_COLORS][MAX_CHANNELS];
  logic signed [DIFF_W-1:0] s1_diff_q [MAX_COLORS][MAX_CHANNELS];
  logic                     s1_last_q;

  always_comb begin
    for (int j = 0; j < MAX_COLORS; j++) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        if (chan_act[k]) begin
          s1_diff_d[j][k] = $signed({in_value[k][SAMPLE_BITS-1], in_value[k]})
                          - $signed({palette_q[j][k][SAMPLE_BITS-1], palette_q[j][k]});
        end else begin
          s1_diff_d[j][k] = '0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: squares; stage 3: channel sums with inactive colours parked
  // -------------------------------------------------------------------------
  logic [SQ_W-1:0]   s2_sq_q [MAX_COLORS][MAX_CHANNELS];
  logic              s2_last_q;
  logic [DIST_W-1:0] s3_sum_d  [MAX_COLORS];
  logic [DIST_W-1:0] s3_dist_q [MAX_COLORS];
  logic              s3_last_q;

  always_comb begin
    for (int j = 0; j < MAX_COLORS; j++) begin
      s3_sum_d[j] = '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        s3_sum_d[j] = s3_sum_d[j] + DIST_W'(s2_sq_q[j][k]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Min tree: heap order, root at 1, leaves at NPOW..2*NPOW-1
  // -------------------------------------------------------------------------
  logic [DIST_W-1:0] all_dist [1:2*NPOW-1];
  logic [IDX_W-1:0]  all_idx  [1:2*NPOW-1];
  logic [DIST_W-1:0] node_dist_d [1:NPOW-1];
  logic [IDX_W-1:0]  node_idx_d  [1:NPOW-1];
  logic [DIST_W-1:0] node_dist_q [1:NPOW-1];
  logic [IDX_W-1:0]  node_idx_q  [1:NPOW-1];
  logic [IDX_W-1:0]  tree_l_q;

  always_comb begin
    for (int n = 1; n < NPOW; n++) begin
      all_dist[n] = node_dist_q[n];
      all_idx[n]  = node_idx_q[n];
    end
    // padding leaves never win: strict compare, all-ones distance
    for (int n = NPOW; n < 2 * NPOW; n++) begin
      all_dist[n] = (n - NPOW < MAX_COLORS) ? s3_dist_q[n - NPOW] : '1;
      all_idx[n]  = IDX_W'(n - NPOW);
    end
    // right child replaces left only when strictly nearer
    for (int n = 1; n < NPOW; n++) begin
      if (all_dist[2*n+1] < all_dist[2*n]) begin
        node_dist_d[n] = all_dist[2*n+1];
        node_idx_d[n]  = all_idx[2*n+1];
      end else begin
        node_dist_d[n] = all_dist[2*n];
        node_idx_d[n]  = all_idx[2*n];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output register: colour lookup by the winning index
  // -------------------------------------------------------------------------
  logic [IDX_W-1:0]                  best_idx;
  logic [IDX_W+COLOR_INDEX_W-1:0]    best_ext;
  logic signed [SAMPLE_BITS-1:0]     out_val_d [NUM_VALUE_FIELDS];
  logic signed [SAMPLE_BITS-1:0]     out_val_q [NUM_VALUE_FIELDS];
  logic [COLOR_INDEX_W-1:0]          out_idx_q;
  logic                              out_last_q;

  assign best_idx = node_idx_q[1];
  assign best_ext = {{COLOR_INDEX_W{1'b0}}, best_idx};

  always_comb begin
    for (int k = 0; k < NUM_VALUE_FIELDS; k++) begin
      out_val_d[k] = '0;
    end
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (chan_act[k]) begin
        out_val_d[k] = palette_q[best_idx][k];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Valid bits
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      tree_v_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= in_fire && (in_op == OP_QUANT);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      tree_v_q    <= IDX_W'({tree_v_q, s3_valid_q});
      out_valid_q <= tree_v_q[IDX_W-1];
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_diff_q <= s1_diff_d;
      s1_last_q <= s_axis_tlast;
      for (int j = 0; j < MAX_COLORS; j++) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
          s2_sq_q[j][k] <= SQ_W'(s1_diff_q[j][k] * s1_diff_q[j][k]);
        end
      end
      s2_last_q <= s1_last_q;
      for (int j = 0; j < MAX_COLORS; j++) begin
        s3_dist_q[j] <= color_act[j] ? s3_sum_d[j] : '1;
      end
      s3_last_q   <= s2_last_q;
      node_dist_q <= node_dist_d;
      node_idx_q  <= node_idx_d;
      tree_l_q    <= IDX_W'({tree_l_q, s3_last_q});
      out_idx_q   <= best_ext[COLOR_INDEX_W-1:0];
      out_val_q   <= out_val_d;
      out_last_q  <= tree_l_q[IDX_W-1];
    end
  end

  // -------------------------------------------------------------------------
  // Result beat
  // -------------------------------------------------------------------------
  logic [OUT_W-1:0] out_data;

  always_comb begin
    out_data = '0;
    out_data[COLOR_INDEX_W-1:0] = out_idx_q;
    for (int k = 0; k < NUM_VALUE_FIELDS; k++) begin
      out_data[COLOR_INDEX_W + k * SAMPLE_BITS +: SAMPLE_BITS] = out_val_q[k];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last_q;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `NPQ_ASSERT_NEXT(a_stall_holds_valids, !pipe_en,
    $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s3_valid_q) && $stable(tree_v_q),
    "pipeline valid bits moved during a stall")
  `NPQ_ASSERT_NEXT(a_square_to_sum, pipe_en && s2_valid_q, s3_valid_q,
    "pixel lost between square and sum stages")
  `NPQ_ASSERT_NEXT(a_root_to_output, pipe_en && tree_v_q[IDX_W-1], out_valid_q,
    "pixel lost between min tree root and output register")
  `NPQ_ASSERT_IMPL(a_write_when_clear, in_fire && (in_op == OP_WRITE), !pix_busy,
    "palette written while a pixel is in flight")

endmodule
